// ----- design/ssf_pkg.sv -----
package ssf_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_HALF_WINDOW = 16;
  localparam int RING_DEPTH      = 64;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int H_CAP   = (MAX_HALF_WINDOW < (RING_DEPTH - 1) / 2) ?
                           MAX_HALF_WINDOW : (RING_DEPTH - 1) / 2;
  localparam int CNT_W   = $clog2(2 * H_CAP + 2);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(2 * H_CAP + 1);
  localparam int DIVC_W  = $clog2(SUM_W);

  localparam int MODE_W  = 2;
  localparam int HALF_W  = 5;
  localparam int ALPHA_W = 17;
  localparam int GAIN_W  = 16;
  localparam int OUT_W   = 33;
  localparam int IDX_W   = 32;
  localparam int Y_W     = SAMPLE_BITS + 16;
  localparam int PS_W    = Y_W + 1 + ALPHA_W + 1;
  localparam int PD_W    = SAMPLE_BITS + 1 + GAIN_W + 1;
  localparam int IN_TW   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam logic [MODE_W-1:0] MODE_AVG    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF   = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_HALF  = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;
  localparam logic [1:0] REG_GAIN  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_POST, ST_PLAN, ST_SUM, ST_DIV, ST_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/ssf_ram.sv -----
module ssf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/ssf_div.sv -----
module ssf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ssf_pkg::div_req_t req,
  output ssf_pkg::div_rsp_t rsp
);
  import ssf_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVC_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W:0]    rs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    rs       = {rem_r, quo_r[SUM_W-1]};
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIVC_W'(SUM_W - 1);
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      neg_nxt  = req.dividend[SUM_W-1];
      quo_nxt  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    end else if (busy_r) begin
      // restoring step, one quotient bit per cycle
      if (rs >= {1'b0, dsr_r}) begin
        rem_nxt = CNT_W'(rs - {1'b0, dsr_r});
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rs[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    rsp.busy     = busy_r;
    rsp.done     = done_r;
    rsp.quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);
  end

endmodule

// ----- design/selectable_sample_filter_core.sv -----
// channel | ports                              | payload
// in      | in_tvalid/in_tready/in_tdata/tlast | sample, end_of_record
// out     | out_tvalid/out_tready/out_tdata/.. | filtered, last_out
// cfg     | psel/penable/pwrite/paddr/pwdata.. | four registers at 4*i
// One item at a time. Difference runs MUL, POST, EMIT; smoothing adds WAIT before EMIT.
// Average: per result, ring reads of the window on the single RAM port,
// then the bit-serial divider; a flush repeats this per result.
// Reset is synchronous; ring contents need no clearing (only samples of the
// current record are read). A stalled output holds the block in its emit step.
module selectable_sample_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ssf_pkg::IN_TW-1:0]      in_tdata,   // [15:0] sample
  input  logic                           in_tlast,   // end_of_record
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ssf_pkg::OUT_TW-1:0]     out_tdata,  // [32:0] filtered, rest zero
  output logic                           out_tlast,  // last_out
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ssf_pkg::*;

  // configuration
  logic [MODE_W-1:0]  mode_r;
  logic [HALF_W-1:0]  half_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [1:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_AVG;
      half_r  <= HALF_W'(1);
      alpha_r <= ALPHA_W'(32768);
      gain_r  <= GAIN_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:  mode_r  <= pwdata[MODE_W-1:0];
        REG_HALF:  half_r  <= pwdata[HALF_W-1:0];
        REG_ALPHA: alpha_r <= pwdata[ALPHA_W-1:0];
        REG_GAIN:  gain_r  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:  prdata = 32'(mode_r);
      REG_HALF:  prdata = 32'(half_r);
      REG_ALPHA: prdata = 32'(alpha_r);
      REG_GAIN:  prdata = 32'(gain_r);
      default:   prdata = '0;
    endcase
  end

  // state
  state_t                        state_r, state_nxt;
  logic [RING_AW-1:0]            wp_r, wp_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic signed [Y_W-1:0]         y_r, y_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          started_r, started_nxt;

  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic                          last_r, last_nxt;
  logic [HALF_W-1:0]             h_r, h_nxt;
  logic [IDX_W-1:0]              k_r, k_nxt;
  logic [MODE_W-1:0]             md_r, md_nxt;
  logic signed [PS_W-1:0]        ps_r, ps_nxt;
  logic signed [PD_W-1:0]        pd_r, pd_nxt;
  logic [CNT_W-1:0]              d_r, d_nxt;
  logic [CNT_W-1:0]              hi_r, hi_nxt;
  logic [CNT_W-1:0]              b_r, b_nxt;
  logic                          rdv_r, rdv_nxt;
  logic signed [SUM_W-1:0]       acc_r, acc_nxt;
  logic signed [OUT_W-1:0]       res_r, res_nxt;
  logic                          rlast_r, rlast_nxt;

  logic                          ov_r, ov_nxt;
  logic signed [OUT_W-1:0]       od_r, od_nxt;
  logic                          ol_r, ol_nxt;

  logic                          ram_we;
  logic [RING_AW-1:0]            ram_addr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  div_req_t                      dreq;
  div_rsp_t                      drsp;

  logic [HALF_W-1:0]             h_eff;
  logic [ALPHA_W-1:0]            a_eff;
  logic signed [Y_W:0]           dv;
  logic signed [SAMPLE_BITS:0]   dx;
  logic signed [PS_W-1:0]        ps_mul;
  logic signed [PD_W-1:0]        pd_mul;
  logic signed [PS_W-1:0]        ps_rnd;
  logic signed [Y_W:0]           y_out_t;
  logic signed [63:0]            pd_ext;
  logic [IDX_W-1:0]              dh;

  assign h_eff = (half_r > HALF_W'(H_CAP)) ? HALF_W'(H_CAP) : half_r;
  assign a_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign dv    = (Y_W+1)'($signed({x_r, 16'h0000})) - (Y_W+1)'(y_r);
  assign dx    = (SAMPLE_BITS+1)'(x_r) - (SAMPLE_BITS+1)'(prev_r);
  assign ps_mul  = dv * $signed({1'b0, a_eff});
  assign pd_mul  = dx * $signed({1'b0, gain_r});
  assign ps_rnd  = (ps_r + PS_W'(32768)) >>> 16;
  assign y_out_t = ((Y_W+1)'(y_r) + (Y_W+1)'(32768)) >>> 16;
  assign pd_ext  = 64'(pd_r);
  assign dh      = IDX_W'(d_r) + IDX_W'(h_r);

  ssf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata[SAMPLE_BITS-1:0]),
    .rdata (ram_rdata)
  );

  ssf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r      <= '0;
      idx_r     <= '0;
      y_r       <= '0;
      prev_r    <= '0;
      started_r <= 1'b0;
      rdv_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      idx_r     <= idx_nxt;
      y_r       <= y_nxt;
      prev_r    <= prev_nxt;
      started_r <= started_nxt;
      rdv_r     <= rdv_nxt;
      ov_r      <= ov_nxt;
    end
    x_r     <= x_nxt;
    last_r  <= last_nxt;
    h_r     <= h_nxt;
    k_r     <= k_nxt;
    md_r    <= md_nxt;
    ps_r    <= ps_nxt;
    pd_r    <= pd_nxt;
    d_r     <= d_nxt;
    hi_r    <= hi_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    rlast_r <= rlast_nxt;
    od_r    <= od_nxt;
    ol_r    <= ol_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    idx_nxt     = idx_r;
    y_nxt       = y_r;
    prev_nxt    = prev_r;
    started_nxt = started_r;
    x_nxt       = x_r;
    last_nxt    = last_r;
    h_nxt       = h_r;
    k_nxt       = k_r;
    md_nxt      = md_r;
    ps_nxt      = ps_r;
    pd_nxt      = pd_r;
    d_nxt       = d_r;
    hi_nxt      = hi_r;
    b_nxt       = b_r;
    rdv_nxt     = 1'b0;
    acc_nxt     = acc_r;
    res_nxt     = res_r;
    rlast_nxt   = rlast_r;
    ov_nxt      = ov_r && !out_tready;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    ram_we      = 1'b0;
    ram_addr    = wp_r;
    dreq.start    = 1'b0;
    dreq.dividend = acc_r;
    dreq.divisor  = hi_r + 1'b1;
    in_tready   = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ram_we   = 1'b1;
          wp_nxt   = wp_r + 1'b1;
          x_nxt    = $signed(in_tdata[SAMPLE_BITS-1:0]);
          last_nxt = in_tlast;
          h_nxt    = h_eff;
          k_nxt    = idx_r;
          md_nxt   = mode_r;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ps_nxt = ps_mul;
        pd_nxt = pd_mul;
        state_nxt = ST_POST;
      end
      ST_POST: begin
        if (!started_r) begin
          y_nxt = $signed({x_r, 16'h0000});
        end else begin
          y_nxt = y_r + Y_W'(ps_rnd);
        end
        prev_nxt = x_r;
        if (last_r) begin
          idx_nxt     = '0;
          started_nxt = 1'b0;
        end else begin
          if (idx_r != '1) begin
            idx_nxt = idx_r + 1'b1;
          end
          started_nxt = 1'b1;
        end
        rlast_nxt = last_r;
        state_nxt = ST_IDLE;
        case (md_r)
          MODE_SMOOTH: begin
            // output is taken from y_r once it holds this item's update
            state_nxt = ST_WAIT;
          end
          MODE_DIFF: begin
            if (!started_r) begin
              res_nxt = '0;
            end else if (pd_ext > 64'sd4294967295) begin
              res_nxt = OUT_W'(64'sd4294967295);
            end else if (pd_ext < -64'sd4294967296) begin
              res_nxt = OUT_W'(-64'sd4294967296);
            end else begin
              res_nxt = OUT_W'(pd_ext);
            end
            state_nxt = ST_EMIT;
          end
          MODE_AVG: begin
            if (last_r) begin
              d_nxt = (IDX_W'(h_r) < k_r) ? CNT_W'(h_r) : CNT_W'(k_r);
              state_nxt = ST_PLAN;
            end else if (k_r >= IDX_W'(h_r)) begin
              d_nxt = CNT_W'(h_r);
              state_nxt = ST_PLAN;
            end
          end
          default: ;
        endcase
      end
      ST_PLAN: begin
        hi_nxt  = (dh < k_r) ? CNT_W'(dh) : CNT_W'(k_r);
        b_nxt   = '0;
        acc_nxt = '0;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // newest sample sits at wp_r - 1; read b samples further back
        ram_addr = wp_r - RING_AW'(1) - RING_AW'(b_r);
        if (b_r <= hi_r) begin
          b_nxt   = b_r + 1'b1;
          rdv_nxt = 1'b1;
        end
        if (rdv_r) begin
          acc_nxt = acc_r + SUM_W'($signed(ram_rdata));
        end else if (b_r > hi_r) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        dreq.start = 1'b1;
        state_nxt  = ST_WAIT;
      end
      ST_WAIT: begin
        if (md_r == MODE_SMOOTH) begin
          res_nxt   = OUT_W'(y_out_t);
          state_nxt = ST_EMIT;
        end else if (drsp.done) begin
          res_nxt   = OUT_W'(drsp.quotient);
          rlast_nxt = last_r && (d_r == '0);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = res_r;
          ol_nxt = rlast_r;
          if (md_r == MODE_AVG && last_r && d_r != '0) begin
            d_nxt     = d_r - 1'b1;
            state_nxt = ST_PLAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_TW'($unsigned(od_r));
  assign out_tlast  = ol_r;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !drsp.busy)
    else $error("divider busy while block idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_MUL)
    else $error("accepted item did not start processing");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> b_r <= hi_r + 1'b1)
    else $error("ring read count overran window");

endmodule
